// ===== hdl/slvg_pkg.sv =====
// ----------------------------------------------------------------------------
// slvg_pkg: shared types and constants of the velocity governor
// Field widths, zone and register codes, and the words that travel between
// the front end, the divider pipeline and the top level.
// ----------------------------------------------------------------------------
package slvg_pkg;

	localparam int unsigned POS_W  = 16;  // measured position, signed
	localparam int unsigned VEL_W  = 15;  // velocity demand, signed
	localparam int unsigned CMD_W  = 11;  // velocity command, signed
	localparam int unsigned ZONE_W = 3;
	localparam int unsigned MAG_W  = 14;  // magnitude of the clamped demand
	localparam int unsigned FAC_W  = 11;  // scale numerator (distance)
	localparam int unsigned DIV_W  = 15;  // divisor, ten times the band width
	localparam int unsigned REM_W  = MAG_W + FAC_W;
	localparam int unsigned QBITS  = 10;  // quotient never exceeds 1023
	localparam int unsigned RNG_W  = 15;
	localparam int unsigned NEAR_W = 11;
	localparam int unsigned VMAX_W = 10;
	localparam int unsigned CFG_W  = 15;
	localparam int unsigned IDX_W  = 2;
	localparam int unsigned EXT_W  = 18;  // room for position against range

	localparam logic [ZONE_W-1:0] ZONE_WITHIN   = 3'd0;
	localparam logic [ZONE_W-1:0] ZONE_NEAR_POS = 3'd1;
	localparam logic [ZONE_W-1:0] ZONE_NEAR_NEG = 3'd2;
	localparam logic [ZONE_W-1:0] ZONE_PAST_POS = 3'd3;
	localparam logic [ZONE_W-1:0] ZONE_PAST_NEG = 3'd4;
	localparam logic [ZONE_W-1:0] ZONE_FAILED   = 3'd5;

	localparam logic [IDX_W-1:0] REG_TRAVEL_LIMIT = 2'd0;
	localparam logic [IDX_W-1:0] REG_SLOW_BAND    = 2'd1;
	localparam logic [IDX_W-1:0] REG_SPEED_CAP    = 2'd2;
	localparam logic [IDX_W-1:0] REG_ENABLE       = 2'd3;

	localparam logic [RNG_W-1:0]  RST_TRAVEL_LIMIT = 15'd1800;
	localparam logic [NEAR_W-1:0] RST_SLOW_BAND    = 11'd100;
	localparam logic [VMAX_W-1:0] RST_SPEED_CAP    = 10'd360;

	typedef struct packed {
		logic [RNG_W-1:0]  travel_limit;
		logic [NEAR_W-1:0] slow_band;
		logic [VMAX_W-1:0] speed_cap;
		logic              enable;
	} slvg_cfg_t;

	// One word in flight through the divider.
	typedef struct packed {
		logic [ZONE_W-1:0]       zone;
		logic                    cmd_valid;
		logic                    force_cmd;  // bypass the quotient
		logic signed [CMD_W-1:0] fixed_cmd;
		logic                    neg;
		logic [REM_W-1:0]        rem;
		logic [DIV_W-1:0]        divisor;
		logic [QBITS-1:0]        quot;
	} slvg_div_t;

endpackage

// ===== hdl/slvg_front.sv =====
// ----------------------------------------------------------------------------
// slvg_front: demand clamp, zone classification and scale product
// Three register stages: compare, select, multiply. Produces the dividend
// and divisor for the divider pipeline.
// ----------------------------------------------------------------------------
module slvg_front
	import slvg_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  slvg_cfg_t               cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [POS_W-1:0] measured_position,
	input  logic                    position_ok,
	input  logic signed [VEL_W-1:0] velocity_demand,
	output logic                    out_valid,
	input  logic                    out_ready,
	output slvg_div_t               out_item
);

	typedef struct packed {
		logic                    ok;
		logic signed [VEL_W-1:0] vc;
		logic                    gt_r;
		logic                    lt_nr;
		logic                    gt_rn;
		logic                    lt_nrn;
		logic signed [EXT_W-1:0] dpos;
		logic signed [EXT_W-1:0] dneg;
	} s1_t;

	typedef struct packed {
		logic [ZONE_W-1:0]       zone;
		logic                    cmd_valid;
		logic                    force_cmd;
		logic signed [CMD_W-1:0] fixed_cmd;
		logic                    neg;
		logic [MAG_W-1:0]        vmag;
		logic [FAC_W-1:0]        factor;
		logic [DIV_W-1:0]        divisor;
	} s2_t;

	logic      vld_s1, vld_s2, vld_s3;
	logic      rdy1, rdy2, rdy3;
	s1_t       d_s1, n1;
	s2_t       d_s2, n2;
	slvg_div_t d_s3, n3;

	assign rdy3     = !vld_s3 || out_ready;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	// Stage 1: clamp the demand and compare the position against the limits.
	logic signed [EXT_W-1:0] p18, r18, n18;
	logic [MAG_W-1:0]        lim;
	logic signed [VEL_W:0]   v16, lim16, nlim16;

	always_comb begin
		p18    = {{(EXT_W-POS_W){measured_position[POS_W-1]}}, measured_position};
		r18    = $signed({{(EXT_W-RNG_W){1'b0}}, cfg.travel_limit});
		n18    = $signed({{(EXT_W-NEAR_W){1'b0}}, cfg.slow_band});
		lim    = ({{(MAG_W-VMAX_W){1'b0}}, cfg.speed_cap} << 3)
			+ ({{(MAG_W-VMAX_W){1'b0}}, cfg.speed_cap} << 1);
		v16    = {velocity_demand[VEL_W-1], velocity_demand};
		lim16  = $signed({{(VEL_W+1-MAG_W){1'b0}}, lim});
		nlim16 = -lim16;
		n1.ok  = position_ok;
		if (v16 > lim16) begin
			n1.vc = lim16[VEL_W-1:0];
		end else if (v16 < nlim16) begin
			n1.vc = nlim16[VEL_W-1:0];
		end else begin
			n1.vc = velocity_demand;
		end
		n1.gt_r   = p18 > r18;
		n1.lt_nr  = p18 < -r18;
		n1.gt_rn  = p18 > (r18 - n18);
		n1.lt_nrn = p18 < (n18 - r18);
		n1.dpos   = r18 - p18;
		n1.dneg   = p18 + r18;
	end

	// Stage 2: pick the zone and the scale, or a fixed command.
	logic                    scaled;
	logic signed [EXT_W-1:0] dsel;
	logic signed [VEL_W-1:0] vneg;
	logic signed [CMD_W-1:0] vmax11;
	logic signed [EXT_W-1:0] nsel;

	always_comb begin
		scaled       = 1'b0;
		dsel         = d_s1.dpos;
		vneg         = -d_s1.vc;
		vmax11       = $signed({1'b0, cfg.speed_cap});
		nsel         = $signed({{(EXT_W-NEAR_W){1'b0}}, cfg.slow_band});
		n2.cmd_valid = d_s1.ok && cfg.enable;
		n2.neg       = d_s1.vc[VEL_W-1];
		n2.vmag      = d_s1.vc[VEL_W-1] ? vneg[MAG_W-1:0] : d_s1.vc[MAG_W-1:0];
		n2.force_cmd = !n2.cmd_valid;
		n2.fixed_cmd = '0;
		n2.factor    = FAC_W'(1);
		n2.divisor   = DIV_W'(10);
		if (!d_s1.ok) begin
			n2.zone = ZONE_FAILED;
		end else if (d_s1.gt_r) begin
			n2.zone      = ZONE_PAST_POS;
			n2.force_cmd = 1'b1;
			n2.fixed_cmd = n2.cmd_valid ? -vmax11 : '0;
		end else if (d_s1.lt_nr) begin
			n2.zone      = ZONE_PAST_NEG;
			n2.force_cmd = 1'b1;
			n2.fixed_cmd = n2.cmd_valid ? vmax11 : '0;
		end else if (d_s1.gt_rn) begin
			n2.zone = ZONE_NEAR_POS;
			scaled  = !d_s1.vc[VEL_W-1] && (cfg.slow_band != '0);
			dsel    = d_s1.dpos;
		end else if (d_s1.lt_nrn) begin
			n2.zone = ZONE_NEAR_NEG;
			scaled  = d_s1.vc[VEL_W-1] && (cfg.slow_band != '0);
			dsel    = d_s1.dneg;
		end else begin
			n2.zone = ZONE_WITHIN;
		end
		if (scaled) begin
			if (dsel[EXT_W-1]) begin
				n2.factor = '0;
			end else if (dsel > nsel) begin
				n2.factor = cfg.slow_band;
			end else begin
				n2.factor = dsel[FAC_W-1:0];
			end
			n2.divisor = ({{(DIV_W-NEAR_W){1'b0}}, cfg.slow_band} << 3)
				+ ({{(DIV_W-NEAR_W){1'b0}}, cfg.slow_band} << 1);
		end
	end

	// Stage 3: dividend is the demand magnitude times the scale numerator.
	always_comb begin
		n3.zone      = d_s2.zone;
		n3.cmd_valid = d_s2.cmd_valid;
		n3.force_cmd = d_s2.force_cmd;
		n3.fixed_cmd = d_s2.fixed_cmd;
		n3.neg       = d_s2.neg;
		n3.rem       = {{(REM_W-MAG_W){1'b0}}, d_s2.vmag}
			* {{(REM_W-FAC_W){1'b0}}, d_s2.factor};
		n3.divisor   = d_s2.divisor;
		n3.quot      = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) d_s1 <= n1;
		if (rdy2 && vld_s1)   d_s2 <= n2;
		if (rdy3 && vld_s2)   d_s3 <= n3;
	end

	assign out_valid = vld_s3;
	assign out_item  = d_s3;

endmodule

// ===== hdl/slvg_divider.sv =====
// ----------------------------------------------------------------------------
// slvg_divider: pipelined restoring divider
// One quotient bit per stage, most significant first, with a valid bit and
// a local stall per stage so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module slvg_divider
	import slvg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  slvg_div_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output slvg_div_t out_item
);

	logic      vld_s [QBITS];
	slvg_div_t d_s   [QBITS];
	logic      rdy   [QBITS+1];

	assign rdy[QBITS] = out_ready;

	for (genvar k = 0; k < QBITS; k++) begin : g_step
		localparam int unsigned B = QBITS - 1 - k;

		slvg_div_t        cur, nxt;
		logic             cur_v;
		logic [REM_W-1:0] dsh;

		if (k == 0) begin : g_first
			assign cur   = in_item;
			assign cur_v = in_valid;
		end else begin : g_next
			assign cur   = d_s[k-1];
			assign cur_v = vld_s[k-1];
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_comb begin
			nxt = cur;
			dsh = {{(REM_W-DIV_W){1'b0}}, cur.divisor} << B;
			if (cur.rem >= dsh) begin
				nxt.rem     = cur.rem - dsh;
				nxt.quot[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && cur_v) d_s[k] <= nxt;
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[QBITS-1];
	assign out_item  = d_s[QBITS-1];

endmodule

// ===== hdl/soft_limit_velocity_governor.sv =====
// ----------------------------------------------------------------------------
// soft_limit_velocity_governor: soft-limit velocity governor for one joint
// Each accepted input word passes through fourteen register stages.
// Throughput is one word per cycle while results are taken; each stage
// stalls only when it is full and the stage after it cannot move, so a waiting
// result holds back the input only once all fourteen stages are full.
// Reset (arst_n low) empties the pipeline and loads the register defaults:
// range 1800, band 100, max velocity 360, disabled.
// ----------------------------------------------------------------------------
module soft_limit_velocity_governor
	import slvg_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_write,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	// input words
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [POS_W-1:0] measured_position,
	input  logic                    position_ok,
	input  logic signed [VEL_W-1:0] velocity_demand,
	// result words
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ZONE_W-1:0]       zone,
	output logic signed [CMD_W-1:0] velocity_command,
	output logic                    command_valid
);

	// Configuration registers. The user must write them only while the pipeline is
	// empty (the block itself does not enforce it), so every stage reads them directly.
	logic [RNG_W-1:0]  travel_limit_q;
	logic [NEAR_W-1:0] slow_band_q;
	logic [VMAX_W-1:0] speed_cap_q;
	logic              enable_q;
	slvg_cfg_t         cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_limit_q <= RST_TRAVEL_LIMIT;
			slow_band_q    <= RST_SLOW_BAND;
			speed_cap_q    <= RST_SPEED_CAP;
			enable_q       <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TRAVEL_LIMIT: travel_limit_q <= cfg_data[RNG_W-1:0];
				REG_SLOW_BAND:    slow_band_q    <= cfg_data[NEAR_W-1:0];
				REG_SPEED_CAP:    speed_cap_q    <= cfg_data[VMAX_W-1:0];
				REG_ENABLE:       enable_q       <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.travel_limit = travel_limit_q;
	assign cfg.slow_band    = slow_band_q;
	assign cfg.speed_cap    = speed_cap_q;
	assign cfg.enable       = enable_q;

	// Front end: stages 1 to 3 clamp the demand, classify the position and
	// form the dividend (demand magnitude times remaining distance) and the
	// divisor (ten times the band width). Unscaled motion uses a factor of
	// one over ten, which gives the same truncation toward zero.
	logic      front_valid, front_ready;
	slvg_div_t front_item;

	slvg_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.measured_position (measured_position),
		.position_ok       (position_ok),
		.velocity_demand   (velocity_demand),
		.out_valid         (front_valid),
		.out_ready         (front_ready),
		.out_item          (front_item)
	);

	// Stages 4 to 13 divide the magnitude, one quotient bit per stage.
	logic      div_valid, div_ready;
	slvg_div_t div_item;

	slvg_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_item   (front_item),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_item  (div_item)
	);

	// Stage 14 is the output register. It restores the sign of the quotient,
	// or takes the fixed command for the past-limit zones and for words that
	// must not drive the servo (disabled or failed read).
	logic                    vld_s14;
	logic [ZONE_W-1:0]       zone_s14;
	logic signed [CMD_W-1:0] cmd_s14;
	logic                    cvalid_s14;
	logic signed [CMD_W-1:0] mag;
	logic signed [CMD_W-1:0] cmd_n;

	assign div_ready = !vld_s14 || out_ready;

	always_comb begin
		mag = $signed({{(CMD_W-QBITS){1'b0}}, div_item.quot});
		if (div_item.force_cmd) begin
			cmd_n = div_item.fixed_cmd;
		end else if (div_item.neg) begin
			cmd_n = -mag;
		end else begin
			cmd_n = mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s14 <= 1'b0;
		end else if (div_ready) begin
			vld_s14 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ready && div_valid) begin
			zone_s14   <= div_item.zone;
			cmd_s14    <= cmd_n;
			cvalid_s14 <= div_item.cmd_valid;
		end
	end

	assign out_valid        = vld_s14;
	assign zone             = zone_s14;
	assign velocity_command = cmd_s14;
	assign command_valid    = cvalid_s14;

endmodule

// ===== sim/soft_limit_velocity_governor_tb.sv =====
// ----------------------------------------------------------------------------
// soft_limit_velocity_governor_tb: self-checking bench for the joint governor
// Drives position/demand words through the valid/ready input port, rewrites
// the limit registers between phases, and compares every result word
// against an in-bench prediction of the zone and the governed command.
// ----------------------------------------------------------------------------
module soft_limit_velocity_governor_tb
	import slvg_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// One predicted result word.
	typedef struct packed {
		logic [ZONE_W-1:0]       zone;
		logic signed [CMD_W-1:0] velocity_command;
		logic                    command_valid;
	} governor_result_t;

	// Scoreboard: holds a mirror of the registers, predicts the result of
	// each accepted input word and checks result words in order.
	class governor_scoreboard;
		slvg_cfg_t        cfg;
		governor_result_t predicted_words[$];
		int               errors;

		function new();
			cfg.travel_limit = RST_TRAVEL_LIMIT;
			cfg.slow_band = RST_SLOW_BAND;
			cfg.speed_cap = RST_SPEED_CAP;
			cfg.enable = 1'b0;
			errors = 0;
		endfunction

		function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_TRAVEL_LIMIT: cfg.travel_limit = data[RNG_W-1:0];
				REG_SLOW_BAND:    cfg.slow_band = data[NEAR_W-1:0];
				REG_SPEED_CAP:    cfg.speed_cap = data[VMAX_W-1:0];
				REG_ENABLE:       cfg.enable = data[0];
				default:          ;
			endcase
		endfunction

		// Scale a demand by the room left before a limit, as a fraction of
		// the band width clamped to [0, 1]; division truncates toward zero.
		function longint scale_by_room(longint v, longint room, longint n);
			if (n <= 0)
				return v / 10;
			if (room < 0)
				room = 0;
			if (room > n)
				room = n;
			return (v * room) / (10 * n);
		endfunction

		function governor_result_t predict_command(logic signed [POS_W-1:0] pos,
				logic ok, logic signed [VEL_W-1:0] vel);
			longint           p, v, r, n, vmax, lim, cmd;
			governor_result_t res;
			p = longint'(pos);
			v = longint'(vel);
			r = longint'(cfg.travel_limit);
			n = longint'(cfg.slow_band);
			vmax = longint'(cfg.speed_cap);
			lim = vmax * 10;
			cmd = 0;
			if (v > lim)
				v = lim;
			if (v < -lim)
				v = -lim;
			if (!ok) begin
				res.zone = ZONE_FAILED;
			end else if (p > r) begin
				res.zone = ZONE_PAST_POS;
				cmd = -vmax;
			end else if (p < -r) begin
				res.zone = ZONE_PAST_NEG;
				cmd = vmax;
			end else if (p > r - n) begin
				res.zone = ZONE_NEAR_POS;
				cmd = (v < 0) ? v / 10 : scale_by_room(v, r - p, n);
			end else if (p < -r + n) begin
				res.zone = ZONE_NEAR_NEG;
				cmd = (v > 0) ? v / 10 : scale_by_room(v, p + r, n);
			end else begin
				res.zone = ZONE_WITHIN;
				cmd = v / 10;
			end
			res.command_valid = ok && cfg.enable;
			if (!res.command_valid)
				cmd = 0;
			res.velocity_command = cmd[CMD_W-1:0];
			return res;
		endfunction

		function void note_word(logic signed [POS_W-1:0] pos, logic ok,
				logic signed [VEL_W-1:0] vel);
			predicted_words.push_back(predict_command(pos, ok, vel));
		endfunction

		function void check_word(logic [ZONE_W-1:0] z, logic signed [CMD_W-1:0] c,
				logic v);
			governor_result_t want;
			if (predicted_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word: zone %0d, command %0d, valid %0b",
					$time, z, c, v);
				return;
			end
			want = predicted_words.pop_front();
			if (want.zone !== z) begin
				errors++;
				$display("%0t: zone mismatch: expected %0d, actual %0d",
					$time, want.zone, z);
			end
			if (want.velocity_command !== c) begin
				errors++;
				$display("%0t: velocity_command mismatch: expected %0d, actual %0d",
					$time, want.velocity_command, c);
			end
			if (want.command_valid !== v) begin
				errors++;
				$display("%0t: command_valid mismatch: expected %0b, actual %0b",
					$time, want.command_valid, v);
			end
		endfunction

		function int pending();
			return predicted_words.size();
		endfunction
	endclass

	// Every input of the block starts at a known value; reset is held low
	// from time zero.
	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_write = 1'b0;
	logic [IDX_W-1:0]        cfg_index = REG_TRAVEL_LIMIT;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [POS_W-1:0] measured_position = '0;
	logic                    position_ok = 1'b0;
	logic signed [VEL_W-1:0] velocity_demand = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [ZONE_W-1:0]       zone;
	logic signed [CMD_W-1:0] velocity_command;
	logic                    command_valid;

	// Percent of cycles in which each side idles, and a hold-off count that
	// the result side burns down in its own process.
	int unsigned sender_idle_pct = 31;
	int unsigned sink_idle_pct = 31;
	int unsigned stall_left = 0;

	governor_scoreboard sb = new();

	soft_limit_velocity_governor u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.measured_position(measured_position),
		.position_ok      (position_ok),
		.velocity_demand  (velocity_demand),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.zone             (zone),
		.velocity_command (velocity_command),
		.command_valid    (command_valid)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Watchdog. It stops the run and reports a failure if the bench has not
	// finished first.
	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

	// Result side. Values sampled at the rising edge are the ones from just
	// before it, since the block and this bench both update with
	// nonblocking assignments. A word moves when out_valid and out_ready
	// were both high. The next ready is then chosen: forced low during a
	// hold-off, otherwise random at the current idle rate.
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_word(zone, velocity_command, command_valid);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	function automatic longint rand_between(longint lo, longint hi);
		return lo + longint'($urandom_range(32'(hi - lo)));
	endfunction

	// Positions are steered toward the two slow-down bands and the limits,
	// where the interesting arithmetic lives; the rest spread over the
	// legal travel and over the whole 16-bit field.
	function automatic logic signed [POS_W-1:0] pick_position(longint r, longint n);
		int unsigned mode;
		longint      p;
		mode = $urandom_range(99);
		if (mode < 25)
			p = rand_between(r - n - 3, r + 3);
		else if (mode < 50)
			p = rand_between(-r - 3, -r + n + 3);
		else if (mode < 70)
			p = rand_between(-r, r);
		else if (mode < 85)
			p = rand_between(-18000, 18000);
		else
			p = rand_between(-32768, 32767);
		return p[POS_W-1:0];
	endfunction

	// Demands mostly sit around the clamp level, with some full-field values,
	// exact extremes, small values within 25 of zero, and plain zero.
	function automatic logic signed [VEL_W-1:0] pick_demand(longint lim);
		int unsigned mode;
		longint      v;
		mode = $urandom_range(99);
		if (mode < 55)
			v = rand_between(-lim - 20, lim + 20);
		else if (mode < 75)
			v = rand_between(-16384, 16383);
		else if (mode < 85) begin
			case ($urandom_range(3))
				0:       v = -16384;
				1:       v = 16383;
				2:       v = lim;
				default: v = -lim;
			endcase
		end else if (mode < 95)
			v = rand_between(-25, 25);
		else
			v = 0;
		return v[VEL_W-1:0];
	endfunction

	// Offer one word. Valid stays high from the previous word unless an idle
	// cycle is drawn, so it is never lowered and raised in the same step.
	task automatic send_word(logic signed [POS_W-1:0] pos, logic ok,
			logic signed [VEL_W-1:0] vel);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		measured_position <= pos;
		position_ok <= ok;
		velocity_demand <= vel;
		do @(posedge clk); while (!in_ready);
		sb.note_word(pos, ok, vel);
	endtask

	// Stop offering and wait for every predicted word to come back, then let
	// the pipeline settle for a little more than its latency.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Write enable stays high across back-to-back writes and drops after the
	// last one.
	task automatic write_register(logic [IDX_W-1:0] idx, int unsigned data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(data);
		@(posedge clk);
		sb.set_register(idx, CFG_W'(data));
	endtask

	task automatic load_settings(int unsigned rng, int unsigned near,
			int unsigned vmax, int unsigned en);
		write_register(REG_TRAVEL_LIMIT, rng);
		write_register(REG_SLOW_BAND, near);
		write_register(REG_SPEED_CAP, vmax);
		write_register(REG_ENABLE, en);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned rng, near, vmax, en;
		longint      lim;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Straight out of reset the servo is disabled: zones still come out,
		// commands are held at zero.
		send_word(0, 1'b1, 0);
		send_word(1750, 1'b1, 1000);
		drain_results();

		// Directed words at the default limits (1800 range, 100 band, 360 max).
		load_settings(32'(RST_TRAVEL_LIMIT), 32'(RST_SLOW_BAND), 32'(RST_SPEED_CAP), 1);
		send_word(0, 1'b1, 16383);          // clamped to +max
		send_word(0, 1'b1, -16384);         // clamped to -max
		send_word(0, 1'b1, 1234);
		send_word(0, 1'b1, -1239);          // truncates toward zero
		send_word(1750, 1'b1, 1000);        // toward the positive limit, half band
		send_word(1750, 1'b1, -1000);       // away from the positive limit
		send_word(-1750, 1'b1, -1000);      // toward the negative limit
		send_word(-1750, 1'b1, 1000);       // away from the negative limit
		send_word(1800, 1'b1, 3000);        // sitting on the limit: no room left
		send_word(-1800, 1'b1, -3000);
		send_word(1801, 1'b1, 3000);        // just past: full speed back
		send_word(-1801, 1'b1, -3000);
		send_word(1700, 1'b1, 2000);        // band edge, still within
		send_word(1701, 1'b1, 2000);        // first step into the band
		send_word(-1700, 1'b1, -2000);
		send_word(-1701, 1'b1, -2000);
		send_word(32767, 1'b1, 5);          // field extremes of the position
		send_word(-32768, 1'b1, -5);
		send_word(0, 1'b0, 500);            // failed reads
		send_word(20000, 1'b0, -500);
		send_word(1750, 1'b1, 0);           // zero demand inside the band
		send_word(0, 1'b1, 0);
		drain_results();

		// Random phases, each with its own register settings. The first uses the
		// defaults and the next five pin the extremes: widest limits, zero range
		// with the narrowest band, a band wider than the range, a zero band, and disabled.
		for (int ph = 0; ph < 11; ph++) begin
			sender_idle_pct = 31;
			sink_idle_pct = 31;
			en = 1;
			case (ph)
				0: begin
					rng = 1800; near = 100; vmax = 360;
				end
				1: begin
					// No random idling on either side for the whole phase.
					rng = 18000; near = 1800; vmax = 1000;
					sender_idle_pct = 0;
					sink_idle_pct = 0;
				end
				2: begin
					rng = 0; near = 1; vmax = 0;
				end
				3: begin
					rng = 50; near = 1800; vmax = 500;
				end
				4: begin
					rng = 1000; near = 0; vmax = 700;
				end
				5: begin
					rng = 18000; near = 1; vmax = 1000; en = 0;
				end
				default: begin
					rng = $urandom_range(18000);
					near = $urandom_range(1800, 1);
					vmax = $urandom_range(1000);
					en = ($urandom_range(99) < 85) ? 1 : 0;
				end
			endcase
			load_settings(rng, near, vmax, en);
			lim = longint'(vmax) * 10;
			for (int k = 0; k < 120; k++) begin
				// Hold the result side off while words keep coming, so the
				// pipeline fills and the input side backs up.
				if (ph == 1 && k == 20)
					stall_left = 150;
				// Let everything in flight come back before going on.
				if (ph == 0 && k == 60)
					drain_results();
				send_word(pick_position(longint'(rng), longint'(near)),
					$urandom_range(99) < 90, pick_demand(lim));
			end
			drain_results();
		end

		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
